// File: src/bqt_pkg.sv
package bqt_pkg;

	// Field widths
	localparam int WORD_W  = 32;
	localparam int STEP_W  = 3;
	localparam int SCALE_W = 24;
	localparam int CFG_W   = 24;
	localparam int RECIP_W = 39;

	// Register map
	localparam logic [0:0] REG_TESS_LEVEL   = 1'b0;
	localparam logic [0:0] REG_SCALE_FACTOR = 1'b1;

	// Register reset values and level limits
	localparam logic [STEP_W-1:0]  LEVEL_RESET = 3'd5;
	localparam logic [STEP_W-1:0]  LEVEL_MIN   = 3'd1;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;

	// Grid position carried alongside each value
	typedef struct packed {
		logic [STEP_W-1:0] row;
		logic [STEP_W-1:0] col;
		logic              last;
	} bqt_tag_t;

	// floor(2^38 / level^2): reciprocal of the rounding divisor 2*level^2 at 2^39
	function automatic logic [RECIP_W-1:0] recip(input logic [STEP_W-1:0] level);
		logic [RECIP_W-1:0] r;
		begin
			case (level)
				3'd2:    r = 39'd68719476736;
				3'd3:    r = 39'd30541989660;
				3'd4:    r = 39'd17179869184;
				3'd5:    r = 39'd10995116277;
				3'd6:    r = 39'd7635497415;
				3'd7:    r = 39'd5609753202;
				default: r = 39'd274877906944;
			endcase
			return r;
		end
	endfunction

endpackage

// File: src/biquadratic_patch_tessellator.sv
// The row lane emits one result per cycle within a row; before a row it waits for the
// 4-stage column lanes when their values for that row are not yet ready.
// busy stays high from acceptance until the cycle after the last result strobe.
// Asynchronous reset clears control state and sets level 5 and scale 1.0; results
// are strobed for one cycle and cannot be stalled.
module biquadratic_patch_tessellator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic signed [31:0]  ctl_r0c0,
	input  logic signed [31:0]  ctl_r0c1,
	input  logic signed [31:0]  ctl_r0c2,
	input  logic signed [31:0]  ctl_r1c0,
	input  logic signed [31:0]  ctl_r1c1,
	input  logic signed [31:0]  ctl_r1c2,
	input  logic signed [31:0]  ctl_r2c0,
	input  logic signed [31:0]  ctl_r2c1,
	input  logic signed [31:0]  ctl_r2c2,
	input  logic                apply_scale,
	input  logic                cfg_we,
	input  logic [0:0]          cfg_index,
	input  logic [23:0]         cfg_data,
	output logic                result_valid,
	output logic signed [31:0]  value,
	output logic [2:0]          row_step,
	output logic [2:0]          col_step,
	output logic                last
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_FILL  = 5'b00010,
		ST_WAIT  = 5'b00100,
		ST_ROW   = 5'b01000,
		ST_DRAIN = 5'b10000
	} state_t;

	state_t                     state_q;
	logic [2:0]                 lvl_cfg_q;
	logic [23:0]                scale_q;
	logic [2:0]                 lv_q, j_q, k_q;
	logic                       scl_en_q;
	logic signed [31:0]         ctl_q [3][3];
	logic signed [31:0]         colv_q [3];
	logic signed [31:0]         coln_q [3];
	logic                       coln_vld_q;

	logic                       accept;
	logic                       col_issue, row_issue;
	logic [2:0]                 col_i;
	logic                       nxt_rdy, consume;
	logic signed [31:0]         nxt_val [3];
	logic                       lane_done [3];
	logic signed [31:0]         lane_res [3];
	logic                       lane_vld;
	bqt_pkg::bqt_tag_t          row_tag;
	logic                       row_done;
	logic signed [31:0]         row_res;
	bqt_pkg::bqt_tag_t          row_tag_out;
	logic                       sc_vld;
	logic signed [31:0]         sc_val;
	bqt_pkg::bqt_tag_t          sc_tag;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign lane_vld = lane_done[0];
	assign nxt_rdy  = coln_vld_q || lane_vld;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_cfg_q <= bqt_pkg::LEVEL_RESET;
			scale_q   <= bqt_pkg::SCALE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				bqt_pkg::REG_TESS_LEVEL:   lvl_cfg_q <= cfg_data[2:0];
				bqt_pkg::REG_SCALE_FACTOR: scale_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer outputs: column issue for the next row, row issue per column step
	always_comb begin
		col_issue = 1'b0;
		col_i     = j_q;
		row_issue = 1'b0;
		consume   = 1'b0;
		case (state_q)
			ST_FILL: col_issue = 1'b1;
			ST_WAIT: consume = nxt_rdy;
			ST_ROW: begin
				row_issue = 1'b1;
				if (k_q == 3'd0 && j_q != lv_q) begin
					col_issue = 1'b1;
					col_i     = j_q + 3'd1;
				end
				consume = (k_q == lv_q) && (j_q != lv_q) && nxt_rdy;
			end
			default: ;
		endcase
		row_tag.row  = j_q;
		row_tag.col  = k_q;
		row_tag.last = (j_q == lv_q) && (k_q == lv_q);
		for (int c = 0; c < 3; c++) begin
			nxt_val[c] = lane_vld ? lane_res[c] : coln_q[c];
		end
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			lv_q       <= bqt_pkg::LEVEL_MIN;
			j_q        <= 3'd0;
			k_q        <= 3'd0;
			coln_vld_q <= 1'b0;
		end else begin
			if (consume) begin
				coln_vld_q <= 1'b0;
			end else if (lane_vld) begin
				coln_vld_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_FILL;
						lv_q    <= (lvl_cfg_q == 3'd0) ? bqt_pkg::LEVEL_MIN : lvl_cfg_q;
						j_q     <= 3'd0;
						k_q     <= 3'd0;
					end
				end
				ST_FILL: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (nxt_rdy) begin
						state_q <= ST_ROW;
						k_q     <= 3'd0;
					end
				end
				ST_ROW: begin
					if (k_q == lv_q) begin
						if (j_q == lv_q) begin
							state_q <= ST_DRAIN;
						end else begin
							j_q <= j_q + 3'd1;
							k_q <= 3'd0;
							if (!nxt_rdy) begin
								state_q <= ST_WAIT;
							end
						end
					end else begin
						k_q <= k_q + 3'd1;
					end
				end
				ST_DRAIN: begin
					if (sc_vld && sc_tag.last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the control grid and column values
	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_q[0][0] <= ctl_r0c0;
			ctl_q[0][1] <= ctl_r0c1;
			ctl_q[0][2] <= ctl_r0c2;
			ctl_q[1][0] <= ctl_r1c0;
			ctl_q[1][1] <= ctl_r1c1;
			ctl_q[1][2] <= ctl_r1c2;
			ctl_q[2][0] <= ctl_r2c0;
			ctl_q[2][1] <= ctl_r2c1;
			ctl_q[2][2] <= ctl_r2c2;
			scl_en_q    <= apply_scale;
		end
		if (lane_vld) begin
			coln_q <= lane_res;
		end
		if (consume) begin
			colv_q <= nxt_val;
		end
	end

	// Column lanes: one per control column
	for (genvar c = 0; c < 3; c++) begin : g_lane
		bqt_quad_eval u_col (
			.clk     (clk),
			.arst_n  (arst_n),
			.issue   (col_issue),
			.p0      (ctl_q[0][c]),
			.p1      (ctl_q[1][c]),
			.p2      (ctl_q[2][c]),
			.step    (col_i),
			.level   (lv_q),
			.tag_in  ('0),
			.done    (lane_done[c]),
			.result  (lane_res[c]),
			.tag_out ()
		);
	end

	// Merge: curve through the three column values
	bqt_quad_eval u_row (
		.clk     (clk),
		.arst_n  (arst_n),
		.issue   (row_issue),
		.p0      (colv_q[0]),
		.p1      (colv_q[1]),
		.p2      (colv_q[2]),
		.step    (k_q),
		.level   (lv_q),
		.tag_in  (row_tag),
		.done    (row_done),
		.result  (row_res),
		.tag_out (row_tag_out)
	);

	bqt_scale u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_vld       (row_done),
		.in_val       (row_res),
		.in_tag       (row_tag_out),
		.scale_en     (scl_en_q),
		.scale_factor (scale_q),
		.out_vld      (sc_vld),
		.out_val      (sc_val),
		.out_tag      (sc_tag)
	);

	assign result_valid = sc_vld;
	assign value        = sc_val;
	assign row_step     = sc_tag.row;
	assign col_step     = sc_tag.col;
	assign last         = sc_tag.last;

	a_result_in_item: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result strobe outside an item");

	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last) |=> !busy)
		else $error("item not closed after its final result");

	a_lanes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(lane_done[0] == lane_done[1]) && (lane_done[0] == lane_done[2]))
		else $error("column lanes out of step");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		lane_vld |-> !coln_vld_q)
		else $error("pending column values overwritten");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (row_step <= lv_q) && (col_step <= lv_q))
		else $error("grid step beyond level");

endmodule

// File: src/bqt_quad_eval.sv
module bqt_quad_eval (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                issue,
	input  logic signed [31:0]  p0,
	input  logic signed [31:0]  p1,
	input  logic signed [31:0]  p2,
	input  logic [2:0]          step,
	input  logic [2:0]          level,
	input  bqt_pkg::bqt_tag_t   tag_in,
	output logic                done,
	output logic signed [31:0]  result,
	output bqt_pkg::bqt_tag_t   tag_out
);

	logic [2:0]                 inv;
	logic [5:0]                 w0, w1, w2, l2;
	logic signed [38:0]         m0, m1, m2;
	logic signed [39:0]         num;
	logic [38:0]                offs;
	logic [38:0]                nprime;

	logic                       vld_s1, vld_s2, vld_s3, vld_s4;
	logic [38:0]                n_s1;
	logic [2:0]                 lvl_s1, lvl_s2, lvl_s3;
	bqt_pkg::bqt_tag_t          tag_s1, tag_s2, tag_s3, tag_s4;
	logic [7:0]                 nlo_s2, nlo_s3;
	logic [37:0]                pp11_s2;
	logic [38:0]                pp10_s2, pp01_s2;
	logic [39:0]                pp00_s2;
	logic [38:0]                rcp;
	logic [77:0]                psum;
	logic [31:0]                q0_s3;
	logic [6:0]                 dvs;
	logic [7:0]                 qd8, r8;
	logic [31:0]                qc;
	logic signed [31:0]         res_s4;

	// Bernstein weights scaled by level^2, then the offset numerator
	always_comb begin
		inv    = level - step;
		w0     = 6'(inv) * 6'(inv);
		w1     = 6'((6'(step) * 6'(inv)) << 1);
		w2     = 6'(step) * 6'(step);
		l2     = 6'(level) * 6'(level);
		m0     = p0 * $signed({1'b0, w0});
		m1     = p1 * $signed({1'b0, w1});
		m2     = p2 * $signed({1'b0, w2});
		num    = 40'(m0) + 40'(m1) + 40'(m2);
		// add level^2 for rounding and 2^32*level^2 to lift into unsigned range
		offs   = 39'({l2, 32'd0}) + 39'(l2);
		nprime = {num[37:0], 1'b0} + offs;
	end

	// Split the reciprocal product into four partial products
	always_comb begin
		rcp  = bqt_pkg::recip(lvl_s1);
		psum = {pp11_s2, 40'd0} + 78'({pp10_s2, 20'd0}) + 78'({pp01_s2, 20'd0})
			+ 78'(pp00_s2);
	end

	// One-step correction: remainder fits in 8 bits, so work mod 256
	always_comb begin
		dvs = {(6'(lvl_s3) * 6'(lvl_s3)), 1'b0};
		qd8 = 8'(q0_s3[7:0] * 8'(dvs));
		r8  = nlo_s3 - qd8;
		qc  = q0_s3 + 32'(r8 >= 8'(dvs));
	end

	// Hold valid bits through the pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		n_s1    <= nprime;
		lvl_s1  <= level;
		tag_s1  <= tag_in;

		pp11_s2 <= n_s1[38:20] * rcp[38:20];
		pp10_s2 <= n_s1[38:20] * rcp[19:0];
		pp01_s2 <= n_s1[19:0] * rcp[38:20];
		pp00_s2 <= n_s1[19:0] * rcp[19:0];
		nlo_s2  <= n_s1[7:0];
		lvl_s2  <= lvl_s1;
		tag_s2  <= tag_s1;

		q0_s3   <= psum[70:39];
		nlo_s3  <= nlo_s2;
		lvl_s3  <= lvl_s2;
		tag_s3  <= tag_s2;

		// drop the 2^31 lift again
		res_s4  <= $signed({~qc[31], qc[30:0]});
		tag_s4  <= tag_s3;
	end

	assign done    = vld_s4;
	assign result  = res_s4;
	assign tag_out = tag_s4;

endmodule

// File: src/bqt_scale.sv
module bqt_scale (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_vld,
	input  logic signed [31:0]  in_val,
	input  bqt_pkg::bqt_tag_t   in_tag,
	input  logic                scale_en,
	input  logic [23:0]         scale_factor,
	output logic                out_vld,
	output logic signed [31:0]  out_val,
	output bqt_pkg::bqt_tag_t   out_tag
);

	localparam logic signed [40:0] SAT_MAX = 41'sd2147483647;
	localparam logic signed [40:0] SAT_MIN = -41'sd2147483648;

	logic                       vld_s1, vld_s2;
	logic signed [56:0]         prod_s1;
	logic signed [31:0]         v_s1, val_s2;
	logic                       en_s1;
	bqt_pkg::bqt_tag_t          tag_s1, tag_s2;
	logic signed [56:0]         biased;
	logic signed [40:0]         full;

	// Round to nearest on the Q8.16 product, then clamp to 32 bits
	always_comb begin
		biased = prod_s1 + 57'sd32768;
		full   = en_s1 ? $signed(biased[56:16]) : 41'(v_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= in_val * $signed({1'b0, scale_factor});
		v_s1    <= in_val;
		en_s1   <= scale_en;
		tag_s1  <= in_tag;
		tag_s2  <= tag_s1;
		if (full > SAT_MAX) begin
			val_s2 <= 32'sh7fffffff;
		end else if (full < SAT_MIN) begin
			val_s2 <= 32'sh80000000;
		end else begin
			val_s2 <= full[31:0];
		end
	end

	assign out_vld = vld_s2;
	assign out_val = val_s2;
	assign out_tag = tag_s2;

endmodule

// File: tb/tb_biquadratic_patch_tessellator.sv
module tb_biquadratic_patch_tessellator;

	localparam int LEVEL_CAP = 7;

	typedef struct packed {
		logic [8:0][bqt_pkg::WORD_W-1:0] ctl;
		logic                            scale_on;
	} patch_t;

	typedef struct packed {
		logic [bqt_pkg::WORD_W-1:0] value;
		bqt_pkg::bqt_tag_t          tag;
	} vertex_t;

	logic clk;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [31:0] ctl_r0c0 = '0, ctl_r0c1 = '0, ctl_r0c2 = '0;
	logic signed [31:0] ctl_r1c0 = '0, ctl_r1c1 = '0, ctl_r1c2 = '0;
	logic signed [31:0] ctl_r2c0 = '0, ctl_r2c1 = '0, ctl_r2c2 = '0;
	logic apply_scale = 1'b0;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = bqt_pkg::REG_TESS_LEVEL;
	logic [bqt_pkg::CFG_W-1:0] cfg_data = '0;
	logic result_valid;
	logic signed [31:0] value;
	logic [2:0] row_step;
	logic [2:0] col_step;
	logic last;

	// register copies used for prediction
	logic [bqt_pkg::STEP_W-1:0]  level_reg = bqt_pkg::LEVEL_RESET;
	logic [bqt_pkg::SCALE_W-1:0] scale_reg = bqt_pkg::SCALE_RESET;

	patch_t  patch_q[$];
	vertex_t vertex_expect[$];
	patch_t  cur_patch;

	int unsigned patches_queued = 0;
	int unsigned patches_taken = 0;
	int unsigned vertices_seen = 0;
	int unsigned saturated_vertices = 0;
	int unsigned mismatches = 0;
	bit [7:0]    levels_hit = '0;
	bit          no_idle = 1'b0;
	int unsigned gap_left = 0;
	bit          gap_after_busy = 1'b0;

	biquadratic_patch_tessellator DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.ctl_r0c0(ctl_r0c0), .ctl_r0c1(ctl_r0c1), .ctl_r0c2(ctl_r0c2),
		.ctl_r1c0(ctl_r1c0), .ctl_r1c1(ctl_r1c1), .ctl_r1c2(ctl_r1c2),
		.ctl_r2c0(ctl_r2c0), .ctl_r2c1(ctl_r2c1), .ctl_r2c2(ctl_r2c2),
		.apply_scale(apply_scale),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.result_valid(result_valid), .value(value),
		.row_step(row_step), .col_step(col_step), .last(last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// floor division for a positive divisor
	function automatic longint floor_quot(input longint n, input longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && n < 0)
			q = q - 1;
		return q;
	endfunction

	// quadratic Bezier blend at t = i/lv, rounded to nearest, ties upward
	function automatic longint bezier_blend(input longint p0, input longint p1,
			input longint p2, input longint i, input longint lv);
		longint den, inv, num;
		den = lv * lv;
		inv = lv - i;
		num = p0 * inv * inv + p1 * 2 * i * inv + p2 * i * i;
		return floor_quot(2 * num + den, 2 * den);
	endfunction

	// apply the Q8.16 scale if asked and clip to 32 bits
	function automatic logic [bqt_pkg::WORD_W-1:0] scale_clip(input longint v, input bit on);
		longint r;
		r = v;
		if (on)
			r = floor_quot(v * longint'(scale_reg) + 32768, 65536);
		if (r > 64'sd2147483647) begin
			r = 64'sd2147483647;
			saturated_vertices++;
		end else if (r < -64'sd2147483648) begin
			r = -64'sd2147483648;
			saturated_vertices++;
		end
		return r[bqt_pkg::WORD_W-1:0];
	endfunction

	// work out every vertex of one patch, row-major
	function automatic void tessellate_patch(input patch_t p);
		longint  pts[9];
		longint  colv[3];
		int      lv;
		vertex_t vx;
		lv = level_reg;
		if (lv < bqt_pkg::LEVEL_MIN)
			lv = bqt_pkg::LEVEL_MIN;
		if (lv > LEVEL_CAP)
			lv = LEVEL_CAP;
		levels_hit[lv] = 1'b1;
		for (int c = 0; c < 9; c++)
			pts[c] = longint'($signed(p.ctl[c]));
		for (int j = 0; j <= lv; j++) begin
			for (int c = 0; c < 3; c++)
				colv[c] = bezier_blend(pts[c], pts[3 + c], pts[6 + c], j, lv);
			for (int k = 0; k <= lv; k++) begin
				vx.value = scale_clip(bezier_blend(colv[0], colv[1], colv[2], k, lv),
					p.scale_on);
				vx.tag.row = 3'(j);
				vx.tag.col = 3'(k);
				vx.tag.last = (j == lv && k == lv);
				vertex_expect.insert(vertex_expect.size(), vx);
			end
		end
	endfunction

	function automatic logic [bqt_pkg::WORD_W-1:0] rand_word();
		logic [bqt_pkg::WORD_W-1:0] w;
		case ($urandom_range(0, 7))
			0: w = 32'h7FFF_FFFF;
			1: w = 32'h8000_0000;
			2: w = 32'($urandom_range(0, 8)) - 32'd4;
			3: begin
				w = $urandom_range(0, 64);
				w = (w - 32'd32) << 16;
			end
			default: w = $urandom;
		endcase
		return w;
	endfunction

	function automatic logic [bqt_pkg::SCALE_W-1:0] rand_scale();
		logic [bqt_pkg::SCALE_W-1:0] s;
		case ($urandom_range(0, 5))
			0: s = 24'hFF_FFFF;
			1: s = '0;
			2: s = bqt_pkg::SCALE_RESET;
			3: s = 24'($urandom_range(0, 24'h03_FFFF));
			default: s = 24'($urandom);
		endcase
		return s;
	endfunction

	function automatic void add_patch(input patch_t p);
		patch_q.insert(patch_q.size(), p);
		patches_queued++;
	endfunction

	// checkerboard grid of two words; equal words give a flat patch
	function automatic void add_checker(input logic [bqt_pkg::WORD_W-1:0] a,
			input logic [bqt_pkg::WORD_W-1:0] b, input bit on);
		patch_t p;
		for (int c = 0; c < 9; c++)
			p.ctl[c] = (c % 2 == 0) ? a : b;
		p.scale_on = on;
		add_patch(p);
	endfunction

	// extremes, flat grids and tiny values that land on rounding ties
	function automatic void add_corners(input bit on);
		patch_t p;
		add_checker('0, '0, on);
		add_checker(32'h7FFF_FFFF, 32'h7FFF_FFFF, on);
		add_checker(32'h8000_0000, 32'h8000_0000, on);
		add_checker(32'h7FFF_FFFF, 32'h8000_0000, on);
		add_checker(32'h8000_0000, 32'h7FFF_FFFF, on);
		for (int c = 0; c < 9; c++)
			p.ctl[c] = 32'(c % 3) - 32'(c / 3) - 32'd1;
		p.scale_on = on;
		add_patch(p);
	endfunction

	function automatic void add_random(input int unsigned count);
		patch_t p;
		for (int unsigned n = 0; n < count; n++) begin
			for (int c = 0; c < 9; c++)
				p.ctl[c] = rand_word();
			p.scale_on = 1'($urandom_range(0, 1));
			add_patch(p);
		end
	endfunction

	task automatic program_reg(input logic [0:0] idx,
			input logic [bqt_pkg::CFG_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == bqt_pkg::REG_TESS_LEVEL)
			level_reg = data[bqt_pkg::STEP_W-1:0];
		else
			scale_reg = data;
	endtask

	// level goes in the low bits; junk above must be dropped by the block
	task automatic program_level(input logic [bqt_pkg::STEP_W-1:0] lvl);
		logic [bqt_pkg::CFG_W-1:0] d;
		d = 24'($urandom);
		d[bqt_pkg::STEP_W-1:0] = lvl;
		program_reg(bqt_pkg::REG_TESS_LEVEL, d);
	endtask

	// hold until every patch is taken and every vertex has come back
	task automatic settle();
		do
			@(posedge clk);
		while (patches_taken != patches_queued || busy || vertex_expect.size() != 0);
		repeat (16) @(posedge clk);
	endtask

	// driver: present patches, predict on acceptance, idle at random
	always @(posedge clk) begin
		logic launch;
		launch = start;
		if (arst_n) begin
			if (start && !busy) begin
				tessellate_patch(cur_patch);
				patches_taken++;
				launch = 1'b0;
				gap_left = no_idle ? 0 : $urandom_range(0, 18);
				gap_after_busy = 1'($urandom_range(0, 1));
			end else if (!start && gap_left > 0 && !(gap_after_busy && busy)) begin
				gap_left--;
			end
			if (!launch && gap_left == 0 && patch_q.size() != 0) begin
				cur_patch = patch_q.pop_front();
				ctl_r0c0 <= cur_patch.ctl[0];
				ctl_r0c1 <= cur_patch.ctl[1];
				ctl_r0c2 <= cur_patch.ctl[2];
				ctl_r1c0 <= cur_patch.ctl[3];
				ctl_r1c1 <= cur_patch.ctl[4];
				ctl_r1c2 <= cur_patch.ctl[5];
				ctl_r2c0 <= cur_patch.ctl[6];
				ctl_r2c1 <= cur_patch.ctl[7];
				ctl_r2c2 <= cur_patch.ctl[8];
				apply_scale <= cur_patch.scale_on;
				launch = 1'b1;
			end
		end
		start <= launch;
	end

	// monitor: compare each strobed vertex with the oldest prediction
	always @(posedge clk) begin
		vertex_t want;
		if (arst_n && result_valid) begin
			vertices_seen++;
			if (vertex_expect.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("vertex with none pending: value %0d row %0d col %0d last %0b",
						value, row_step, col_step, last);
			end else begin
				want = vertex_expect.pop_front();
				if (value !== want.value || row_step !== want.tag.row ||
						col_step !== want.tag.col || last !== want.tag.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("vertex mismatch: want %0d r%0d c%0d l%0b, got %0d r%0d c%0d l%0b",
							$signed(want.value), want.tag.row, want.tag.col, want.tag.last,
							value, row_step, col_step, last);
				end
			end
		end
	end

	// phases of register settings and stimulus
	initial begin
		logic [bqt_pkg::STEP_W-1:0] mid_levels[5];
		mid_levels = '{3'd2, 3'd3, 3'd4, 3'd5, 3'd6};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: level 5, unit scale
		add_corners(1'b0);
		add_corners(1'b1);
		add_random(60);
		settle();

		// coarsest level, scale of zero, back to back
		program_level(3'd1);
		program_reg(bqt_pkg::REG_SCALE_FACTOR, '0);
		no_idle = 1'b1;
		add_random(50);
		settle();

		// finest level, largest scale: saturation on both sides
		program_level(3'd7);
		program_reg(bqt_pkg::REG_SCALE_FACTOR, 24'hFF_FFFF);
		no_idle = 1'b0;
		add_corners(1'b1);
		add_random(70);
		settle();

		// level zero must behave as level one
		program_level(3'd0);
		program_reg(bqt_pkg::REG_SCALE_FACTOR, rand_scale());
		add_corners(1'b1);
		add_random(40);
		settle();

		// remaining levels with assorted scales
		foreach (mid_levels[i]) begin
			program_level(mid_levels[i]);
			program_reg(bqt_pkg::REG_SCALE_FACTOR, rand_scale());
			no_idle = (i % 2 == 1);
			add_random(52);
			settle();
		end

		$display("covered %0d patches and checked %0d vertices (%0d saturated)",
			patches_taken, vertices_seen, saturated_vertices);
		$display("effective levels seen (bit per level): %b, mismatches: %0d",
			levels_hit, mismatches);
		if (mismatches == 0 && vertex_expect.size() == 0) begin
			$display("tb_biquadratic_patch_tessellator passed");
		end else begin
			$display("tb_biquadratic_patch_tessellator failed");
		end
		$finish;
	end

	// give up on a hung block
	initial begin
		#1600000;
		$display("tb_biquadratic_patch_tessellator failed");
		$finish;
	end

endmodule
